FILE: rtl/core/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the next cycle, ignored while in reset
`define SLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("slf assertion failed");

// same, checked during reset as well
`define SLF_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("slf assertion failed");

`endif

FILE: rtl/core/slf_pkg.sv
// package: types, constants and helpers of the link force accumulator
`timescale 1ns / 1ps
package slf_pkg;

    localparam int SLF_NODES  = 1024;
    localparam int IDX_W      = 10;
    localparam int POS_W      = 32;
    localparam int RAD_W      = 31;
    localparam int WT_W       = 16;
    localparam int STR_W      = 24;
    localparam int FORCE_W    = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam int DX_W    = POS_W + 1;
    localparam int ABSD_W  = POS_W;
    localparam int SQ_W    = 2 * ABSD_W + 2;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int RSUM_W  = RAD_W + 1;
    localparam int DIFF_W  = ROOT_W + 2;
    localparam int ADIFF_W = DIFF_W - 1;
    localparam int LW_W    = STR_W + WT_W;
    localparam int FAC_W   = 32;
    localparam int PROD_W  = ABSD_W + FAC_W;
    localparam int HALF_W  = PROD_W / 2;
    localparam int PART_W  = HALF_W + ADIFF_W;
    localparam int NUM_W   = PROD_W + ADIFF_W;
    localparam int DEN_SH  = 17;
    localparam int DEN_W   = ROOT_W + DEN_SH;

    localparam logic [SQ_W-1:0]  MIN_SUM = SQ_W'(429496);
    localparam logic [WT_W-1:0]  C065    = WT_W'(42598);
    localparam logic [STR_W-1:0] STR_RST = STR_W'(65536);

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_LINK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = CFG_IDX_W'(1);

    typedef struct packed {
        logic [1:0]              command;
        logic [IDX_W-1:0]        node_index;
        logic [IDX_W-1:0]        other_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [RAD_W-1:0]        node_radius;
        logic [WT_W-1:0]         link_weight;
    } slf_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]          read_index;
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
    } slf_out_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [RAD_W-1:0]        r;
    } slf_node_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] fx;
        logic signed [FORCE_W-1:0] fy;
    } slf_force_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_OUT,
        ST_LA,
        ST_LB,
        ST_SQR,
        ST_SUM,
        ST_ROOT,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_DIV,
        ST_FA,
        ST_FB,
        ST_WB
    } slf_state_t;

    // saturate a widened sum to the force width
    function automatic logic signed [FORCE_W-1:0] sat_force(
        input logic signed [FORCE_W:0] s
    );
        logic signed [FORCE_W-1:0] res;
        if (s[FORCE_W] != s[FORCE_W-1]) begin
            res = s[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
        end else begin
            res = s[FORCE_W-1:0];
        end
        return res;
    endfunction

    // clamp the quotient magnitude and apply the sign
    function automatic logic signed [FORCE_W-1:0] comp_sat(
        input logic [FORCE_W-1:0] q,
        input logic               ovf,
        input logic               neg
    );
        logic [FORCE_W-1:0] lim;
        logic [FORCE_W-1:0] m;
        lim = neg ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
        m   = (ovf || q > lim) ? lim : q;
        return neg ? -m : m;
    endfunction

endpackage

FILE: rtl/core/slf_ram.sv
// single-port-write, single-port-read synchronous ram with registered read data
`timescale 1ns / 1ps
module slf_ram #(
    parameter int DEPTH = 1024,
    parameter int W     = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/slf_sqrt.sv
// iterative integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
module slf_sqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [slf_pkg::SQ_W-1:0]  radicand,
    output logic [slf_pkg::ROOT_W-1:0] root,
    output logic                      done
);
    import slf_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SQ_W-1:0]   rad_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic              ge;

    assign rem_sh = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= ge ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

FILE: rtl/core/slf_div.sv
// restoring divider, one quotient bit per cycle, with a quotient overflow flag
`timescale 1ns / 1ps
module slf_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [slf_pkg::NUM_W-1:0]    numer,
    input  logic [slf_pkg::DEN_W-1:0]    denom,
    output logic [slf_pkg::FORCE_W-1:0]  quot,
    output logic                         ovf,
    output logic                         done
);
    import slf_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [FORCE_W-1:0] q_reg;
    logic               ovf_reg;
    logic [DEN_W:0]     rem_sh;
    logic               ge;

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            q_reg   <= {q_reg[FORCE_W-2:0], ge};
            ovf_reg <= ovf_reg | q_reg[FORCE_W-1];
        end
    end

    assign quot = q_reg;
    assign ovf  = ovf_reg;
    assign done = done_reg;

endmodule

FILE: rtl/core/spring_link_force_accumulator.sv
// top level: node and force tables, link sequencer, request and result channels
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  request | s_valid s_ready s_data                 | in
//  result  | m_valid m_ready m_data                 | out
//  config  | cfg_valid cfg_ready cfg_index cfg_data | in
//
// load: written at the handshake. read: table read, then output load once any held result is taken.
// link: run time set by the 98-step divider and the 33-step square root.
// reset is synchronous, active low; the tables are not cleared.
// a finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
module spring_link_force_accumulator #(
    parameter int NODES = slf_pkg::SLF_NODES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  slf_pkg::slf_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output slf_pkg::slf_out_t                m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [slf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import slf_pkg::*;

    localparam int AW = $clog2(NODES);

    slf_state_t state_reg, state_next;

    logic [STR_W-1:0] ls_reg;
    logic             uw_reg;
    logic             m_valid_reg;
    slf_out_t         m_data_reg;

    logic [IDX_W-1:0] a_reg;
    logic [IDX_W-1:0] b_reg;
    logic [WT_W-1:0]  w_reg;
    logic             rd_ok_reg;

    logic signed [POS_W-1:0] xa_reg, ya_reg;
    logic [RAD_W-1:0]        ra_reg;
    logic [LW_W-1:0]         lw_reg;
    logic signed [DX_W-1:0]  dx_reg, dy_reg;
    logic [RSUM_W-1:0]       rsum_reg;
    logic [FAC_W-1:0]        fac_reg;
    logic [2*ABSD_W-1:0]     sqx_reg, sqy_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [PROD_W-1:0]       px_reg, py_reg;
    logic [PART_W-1:0]       plx_reg, ply_reg, phx_reg, phy_reg;
    logic signed [FORCE_W-1:0] fx_reg, fy_reg;

    logic            a_ok, b_ok, s_hs, out_load;
    logic            node_re, node_we, force_re, force_we;
    logic [AW-1:0]   node_raddr, force_raddr, force_waddr;
    slf_node_t       node_wdata, node_rdata;
    slf_force_t      force_wdata, force_rdata;

    logic [ABSD_W-1:0]  adx, ady;
    logic [ADIFF_W-1:0] adiff;
    logic [SQ_W-1:0]    sum;
    logic               sum_big;
    logic               sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]  sqrt_root;
    logic               div_start, divx_done, divy_done;
    logic [NUM_W-1:0]   numx, numy;
    logic [FORCE_W-1:0] qx, qy;
    logic               ovfx, ovfy;
    logic [LW_W+WT_W:0] fac_w;
    logic signed [DIFF_W-1:0] two_r, three_rsum;
    logic signed [FORCE_W-1:0] new_x, new_y;

    assign a_ok = 32'(s_data.node_index) < NODES;
    assign b_ok = 32'(s_data.other_index) < NODES;

    assign adx   = dx_reg[DX_W-1] ? ABSD_W'(-dx_reg) : ABSD_W'(dx_reg);
    assign ady   = dy_reg[DX_W-1] ? ABSD_W'(-dy_reg) : ABSD_W'(dy_reg);
    assign adiff = diff_reg[DIFF_W-1] ? ADIFF_W'(-diff_reg) : ADIFF_W'(diff_reg);

    assign sum     = SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
    assign sum_big = sum > MIN_SUM;

    assign fac_w = (LW_W+WT_W+1)'(lw_reg * C065) + (LW_W+WT_W+1)'(1 << 23);

    assign two_r      = $signed({1'b0, sqrt_root, 1'b0});
    assign three_rsum = $signed(DIFF_W'(rsum_reg) * DIFF_W'(3));

    assign numx = NUM_W'(plx_reg) + NUM_W'({phx_reg, {HALF_W{1'b0}}});
    assign numy = NUM_W'(ply_reg) + NUM_W'({phy_reg, {HALF_W{1'b0}}});

    // force update: subtract from the first node, add to the second
    assign new_x = (state_reg == ST_FB)
        ? sat_force({force_rdata.fx[FORCE_W-1], force_rdata.fx} - {fx_reg[FORCE_W-1], fx_reg})
        : sat_force({force_rdata.fx[FORCE_W-1], force_rdata.fx} + {fx_reg[FORCE_W-1], fx_reg});
    assign new_y = (state_reg == ST_FB)
        ? sat_force({force_rdata.fy[FORCE_W-1], force_rdata.fy} - {fy_reg[FORCE_W-1], fy_reg})
        : sat_force({force_rdata.fy[FORCE_W-1], force_rdata.fy} + {fy_reg[FORCE_W-1], fy_reg});

    assign s_hs      = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.command == CMD_READ) begin
                        state_next = ST_RD_OUT;
                    end else if (s_data.command == CMD_LINK && a_ok && b_ok) begin
                        state_next = ST_LA;
                    end
                end
            end
            ST_RD_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LA:   state_next = ST_LB;
            ST_LB:   state_next = ST_SQR;
            ST_SQR:  state_next = ST_SUM;
            ST_SUM:  state_next = sum_big ? ST_ROOT : ST_IDLE;
            ST_ROOT: begin
                if (sqrt_done) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_MUL4;
            ST_MUL4: state_next = ST_DIV;
            ST_DIV: begin
                if (divx_done && divy_done) begin
                    state_next = ST_FA;
                end
            end
            ST_FA:   state_next = ST_FB;
            ST_FB:   state_next = ST_WB;
            ST_WB:   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready     = 1'b0;
        node_re     = 1'b0;
        node_we     = 1'b0;
        node_raddr  = AW'(a_reg);
        force_re    = 1'b0;
        force_we    = 1'b0;
        force_raddr = AW'(a_reg);
        force_waddr = AW'(a_reg);
        force_wdata = '0;
        sqrt_start  = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                node_raddr  = AW'(s_data.node_index);
                force_raddr = AW'(s_data.node_index);
                force_waddr = AW'(s_data.node_index);
                if (s_valid) begin
                    case (s_data.command)
                        CMD_LOAD: begin
                            node_we  = a_ok;
                            force_we = a_ok;
                        end
                        CMD_LINK: node_re  = a_ok && b_ok;
                        CMD_READ: force_re = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_RD_OUT: out_load = !m_valid_reg || m_ready;
            ST_LA: begin
                node_re    = 1'b1;
                node_raddr = AW'(b_reg);
            end
            ST_SUM:  sqrt_start = sum_big;
            ST_MUL4: div_start  = 1'b1;
            ST_FA:   force_re   = 1'b1;
            ST_FB: begin
                force_re    = 1'b1;
                force_raddr = AW'(b_reg);
                force_we    = 1'b1;
                force_wdata = '{fx: new_x, fy: new_y};
            end
            ST_WB: begin
                force_we    = 1'b1;
                force_waddr = AW'(b_reg);
                force_wdata = '{fx: new_x, fy: new_y};
            end
            default: ;
        endcase
    end

    assign node_wdata = '{x: s_data.pos_x, y: s_data.pos_y, r: s_data.node_radius};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            ls_reg      <= STR_RST;
            uw_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_STRENGTH) begin
                    ls_reg <= cfg_data[STR_W-1:0];
                end
                if (cfg_index == REG_WEIGHT) begin
                    uw_reg <= cfg_data[0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.read_index <= a_reg;
            m_data_reg.force_x    <= rd_ok_reg ? force_rdata.fx : '0;
            m_data_reg.force_y    <= rd_ok_reg ? force_rdata.fy : '0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_hs) begin
                    a_reg     <= s_data.node_index;
                    b_reg     <= s_data.other_index;
                    w_reg     <= s_data.link_weight;
                    rd_ok_reg <= a_ok;
                end
            end
            ST_LA: begin
                xa_reg <= node_rdata.x;
                ya_reg <= node_rdata.y;
                ra_reg <= node_rdata.r;
                lw_reg <= LW_W'(ls_reg * w_reg);
            end
            ST_LB: begin
                dx_reg   <= DX_W'(xa_reg) - DX_W'(node_rdata.x);
                dy_reg   <= DX_W'(ya_reg) - DX_W'(node_rdata.y);
                rsum_reg <= RSUM_W'(ra_reg) + RSUM_W'(node_rdata.r);
                fac_reg  <= uw_reg ? FAC_W'(fac_w >> 24) : FAC_W'(ls_reg);
            end
            ST_SQR: begin
                sqx_reg <= adx * adx;
                sqy_reg <= ady * ady;
            end
            ST_ROOT: begin
                if (sqrt_done) begin
                    root_reg <= sqrt_root;
                    diff_reg <= two_r - three_rsum;
                end
            end
            ST_MUL1: begin
                px_reg <= PROD_W'(adx) * PROD_W'(fac_reg);
                py_reg <= PROD_W'(ady) * PROD_W'(fac_reg);
            end
            ST_MUL2: begin
                plx_reg <= PART_W'(px_reg[HALF_W-1:0]) * PART_W'(adiff);
                ply_reg <= PART_W'(py_reg[HALF_W-1:0]) * PART_W'(adiff);
            end
            ST_MUL3: begin
                phx_reg <= PART_W'(px_reg[PROD_W-1:HALF_W]) * PART_W'(adiff);
                phy_reg <= PART_W'(py_reg[PROD_W-1:HALF_W]) * PART_W'(adiff);
            end
            ST_DIV: begin
                if (divx_done && divy_done) begin
                    fx_reg <= comp_sat(qx, ovfx, dx_reg[DX_W-1] != diff_reg[DIFF_W-1]);
                    fy_reg <= comp_sat(qy, ovfy, dy_reg[DX_W-1] != diff_reg[DIFF_W-1]);
                end
            end
            default: ;
        endcase
    end

    slf_ram #(.DEPTH(NODES), .W($bits(slf_node_t))) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (AW'(s_data.node_index)),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    slf_ram #(.DEPTH(NODES), .W($bits(slf_force_t))) u_force_ram (
        .aclk  (aclk),
        .we    (force_we),
        .waddr (force_waddr),
        .wdata (force_wdata),
        .re    (force_re),
        .raddr (force_raddr),
        .rdata (force_rdata)
    );

    slf_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sum),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    slf_div u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (numx),
        .denom   ({root_reg, {DEN_SH{1'b0}}}),
        .quot    (qx),
        .ovf     (ovfx),
        .done    (divx_done)
    );

    slf_div u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (numy),
        .denom   ({root_reg, {DEN_SH{1'b0}}}),
        .quot    (qy),
        .ovf     (ovfy),
        .done    (divy_done)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/slf_checker.sv
// port-level checker for the link force accumulator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module slf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input slf_pkg::slf_in_t               s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input slf_pkg::slf_out_t              m_data,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [slf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [slf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import slf_pkg::*;

    logic rd_req;
    logic cfg_req;

    assign rd_req  = s_valid && s_ready && s_data.command == CMD_READ;
    assign cfg_req = cfg_valid && cfg_ready && cfg_index == REG_STRENGTH && cfg_data[0];

    // a read request holds off the next request in the following cycle
    `SLF_ASSERT_NEXT(a_read_blocks, aclk, aresetn, rd_req, !s_ready)
    // a stalled result is held
    `SLF_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // reset leaves the block idle with no result
    `SLF_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_valid && s_ready && cfg_ready)
    // config stays ready after a strength write whose data bit 0 is set
    `SLF_ASSERT_NEXT(a_cfg_open, aclk, aresetn, cfg_req, cfg_ready)

endmodule

bind spring_link_force_accumulator slf_checker u_slf_checker (.*);
